[rtl/expression_lexer_top_macros.svh]
`ifndef EXPRESSION_LEXER_TOP_MACROS_SVH
`define EXPRESSION_LEXER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ELX_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ELX_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/elx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package elx_pkg;

	localparam int KIND_W = 4;
	localparam int CHAR_W = 8;
	localparam int SPOS_W = 16;
	localparam int LEN_W  = 8;

	localparam int MAX_TOKEN_LEN_DEF = 255;
	localparam int POS_WIDTH_DEF     = 16;

	localparam int RES_MAX  = 3;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd0;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd1;
	localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd2;
	localparam logic [KIND_W-1:0] KIND_BINOP  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_LET    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_NULL   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd7;
	localparam logic [KIND_W-1:0] KIND_EOF    = 4'd8;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] chr;
		logic [SPOS_W-1:0] spos;
		logic [LEN_W-1:0]  len;
		logic              last;
	} token_t;

endpackage

`default_nettype wire

[rtl/elx_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module elx_core #(
	parameter int MAX_TOKEN_LEN = 255,
	parameter int POS_WIDTH     = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          take,
	input  wire logic [elx_pkg::CHAR_W-1:0]    chr,
	input  wire logic                          eos,
	output elx_pkg::token_t                    res [elx_pkg::RES_MAX],
	output logic [elx_pkg::RES_MAX-1:0]        res_vld
);
	import elx_pkg::*;

	localparam logic [1:0] M_IDLE  = 2'd0;
	localparam logic [1:0] M_IDENT = 2'd1;
	localparam logic [1:0] M_NUM   = 2'd2;
	localparam logic [1:0] M_ERR   = 2'd3;

	localparam logic [2:0] PFX_NONE = 3'd0;
	localparam logic [2:0] PFX_L    = 3'd1;
	localparam logic [2:0] PFX_LE   = 3'd2;
	localparam logic [2:0] PFX_LET  = 3'd3;
	localparam logic [2:0] PFX_N    = 3'd4;
	localparam logic [2:0] PFX_NU   = 3'd5;
	localparam logic [2:0] PFX_NUL  = 3'd6;
	localparam logic [2:0] PFX_NULL = 3'd7;

	localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_U     = 8'h75;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

	function automatic logic [2:0] first_prefix(input logic [CHAR_W-1:0] c);
		logic [2:0] p;
		p = PFX_NONE;
		if (c == CH_L) p = PFX_L;
		else if (c == CH_N) p = PFX_N;
		return p;
	endfunction

	function automatic logic [2:0] next_prefix(input logic [2:0] p,
			input logic [CHAR_W-1:0] c);
		logic [2:0] n;
		n = PFX_NONE;
		if (p == PFX_L && c == CH_E) n = PFX_LE;
		else if (p == PFX_LE && c == CH_T) n = PFX_LET;
		else if (p == PFX_N && c == CH_U) n = PFX_NU;
		else if (p == PFX_NU && c == CH_L) n = PFX_NUL;
		else if (p == PFX_NUL && c == CH_L) n = PFX_NULL;
		return n;
	endfunction

	function automatic logic [KIND_W-1:0] run_kind(input logic [1:0] m,
			input logic [2:0] p);
		logic [KIND_W-1:0] k;
		k = KIND_NUMBER;
		if (m == M_IDENT) begin
			if (p == PFX_LET) k = KIND_LET;
			else if (p == PFX_NULL) k = KIND_NULL;
			else k = KIND_IDENT;
		end
		return k;
	endfunction

	logic [1:0]           mode_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH-1:0] start_q;
	logic [LEN_W-1:0]     len_q;
	logic [2:0]           pfx_q;

	logic [1:0]           nxt_mode;
	logic [POS_WIDTH-1:0] nxt_start;
	logic [LEN_W-1:0]     nxt_len;
	logic [2:0]           nxt_pfx;
	logic [POS_WIDTH-1:0] pos_inc;

	logic letter, digit, in_run, extend;
	logic a_v, b_v, c_v, d_v;
	logic [KIND_W-1:0] b_kind;

	assign pos_inc = pos_q + 1'b1;

	always_comb begin
		letter = (chr >= 8'h61 && chr <= 8'h7A) || (chr >= 8'h41 && chr <= 8'h5A);
		digit  = (chr >= 8'h30 && chr <= 8'h39);
		in_run = (mode_q == M_IDENT) || (mode_q == M_NUM);
		extend = (mode_q == M_IDENT && letter) || (mode_q == M_NUM && digit);
		a_v = 1'b0;
		b_v = 1'b0;
		c_v = 1'b0;
		d_v = 1'b0;
		b_kind = KIND_ERROR;
		nxt_mode  = mode_q;
		nxt_start = start_q;
		nxt_len   = len_q;
		nxt_pfx   = pfx_q;
		if (mode_q != M_ERR) begin
			if (extend) begin
				if (len_q < LEN_MAX) nxt_len = len_q + 1'b1;
				if (mode_q == M_IDENT) nxt_pfx = next_prefix(pfx_q, chr);
			end else begin
				a_v = in_run;
				nxt_mode = M_IDLE;
				unique case (chr) inside
					CH_SPACE, CH_NL, CH_TAB: begin
					end
					CH_LPAR: begin
						b_v = 1'b1;
						b_kind = KIND_LPAREN;
					end
					CH_RPAR: begin
						b_v = 1'b1;
						b_kind = KIND_RPAREN;
					end
					CH_EQ: begin
						b_v = 1'b1;
						b_kind = KIND_ASSIGN;
					end
					CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
						b_v = 1'b1;
						b_kind = KIND_BINOP;
					end
					default: begin
						if (letter) begin
							nxt_mode  = M_IDENT;
							nxt_start = pos_q;
							nxt_len   = LEN_ONE;
							nxt_pfx   = first_prefix(chr);
						end else if (digit) begin
							nxt_mode  = M_NUM;
							nxt_start = pos_q;
							nxt_len   = LEN_ONE;
							nxt_pfx   = PFX_NONE;
						end else begin
							b_v = 1'b1;
							nxt_mode = M_ERR;
						end
					end
				endcase
			end
			c_v = eos && (nxt_mode == M_IDENT || nxt_mode == M_NUM);
			d_v = eos && (nxt_mode != M_ERR);
		end
	end

	// slot 0: pending run, slot 1: byte token or final run, slot 2: eof
	always_comb begin
		res[0].kind = run_kind(mode_q, pfx_q);
		res[0].chr  = '0;
		res[0].spos = SPOS_W'(start_q);
		res[0].len  = len_q;
		res[0].last = !(b_v || c_v || d_v);
		if (b_v) begin
			res[1].kind = b_kind;
			res[1].chr  = chr;
			res[1].spos = SPOS_W'(pos_q);
			res[1].len  = LEN_ONE;
		end else begin
			res[1].kind = run_kind(nxt_mode, nxt_pfx);
			res[1].chr  = '0;
			res[1].spos = SPOS_W'(nxt_start);
			res[1].len  = nxt_len;
		end
		res[1].last = !d_v;
		res[2].kind = KIND_EOF;
		res[2].chr  = '0;
		res[2].spos = SPOS_W'(pos_inc);
		res[2].len  = '0;
		res[2].last = 1'b1;
		res_vld = {d_v, b_v || c_v, a_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			pfx_q   <= PFX_NONE;
		end else if (take) begin
			if (eos) begin
				mode_q  <= M_IDLE;
				pos_q   <= '0;
				start_q <= '0;
				len_q   <= '0;
				pfx_q   <= PFX_NONE;
			end else begin
				mode_q  <= nxt_mode;
				pos_q   <= pos_inc;
				start_q <= nxt_start;
				len_q   <= nxt_len;
				pfx_q   <= nxt_pfx;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/elx_rq.sv]
`timescale 1ns / 1ps
`default_nettype none

module elx_rq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire elx_pkg::token_t               wr_tok [elx_pkg::RES_MAX],
	input  wire logic [elx_pkg::RES_MAX-1:0]   wr_vld,
	output logic [elx_pkg::RQ_CNT_W-1:0]       space,
	output logic                               rd_valid,
	input  wire logic                          rd_ready,
	output elx_pkg::token_t                    rd_tok
);
	import elx_pkg::*;

	token_t                mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q;
	logic [RQ_PTR_W-1:0]   rd_ptr_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic [RQ_PTR_W-1:0]   off [RES_MAX];
	logic [RQ_CNT_W-1:0]   nwr;
	logic                  rd;

	always_comb begin
		off[0] = '0;
		for (int i = 1; i < RES_MAX; i++) begin
			off[i] = off[i-1] + RQ_PTR_W'(wr_vld[i-1]);
		end
		nwr = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			nwr = nwr + RQ_CNT_W'(wr_vld[i]);
		end
	end

	assign rd       = rd_valid && rd_ready;
	assign rd_valid = (cnt_q != '0);
	assign rd_tok   = mem[rd_ptr_q];
	assign space    = RQ_CNT_W'(RQ_DEPTH) - cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (wr_en && wr_vld[i]) mem[wr_ptr_q + off[i]] <= wr_tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(nwr);
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (wr_en ? nwr : '0) - RQ_CNT_W'(rd);
		end
	end

endmodule

`default_nettype wire

[rtl/expression_lexer_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                  | dir
// in      | in_valid/in_ready, char_byte, end_of_source | sink
// out     | out_valid/out_ready, token_kind, token_char,  | source
//         | start_pos, token_len, last_of_run            |
// One byte per cycle while the queue has room: input register, combinational decode, 4-entry result queue.
// A byte is decoded when the queue has room for all of its results (up to 3).
// At the earliest, results show once the byte has passed the input register and been written to the queue.
// Reset clears the scan state and empties the queue; the next byte is offset 0.
// A stalled output only blocks input once the queue cannot take the next byte.

module expression_lexer_top #(
	parameter int MAX_TOKEN_LEN = elx_pkg::MAX_TOKEN_LEN_DEF,
	parameter int POS_WIDTH     = elx_pkg::POS_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [elx_pkg::CHAR_W-1:0]  char_byte,
	input  wire logic                        end_of_source,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [elx_pkg::KIND_W-1:0]       token_kind,
	output logic [elx_pkg::CHAR_W-1:0]       token_char,
	output logic [elx_pkg::SPOS_W-1:0]       start_pos,
	output logic [elx_pkg::LEN_W-1:0]        token_len,
	output logic                             last_of_run
);
	import elx_pkg::*;

	logic              vld_s1;
	logic [CHAR_W-1:0] chr_s1;
	logic              eos_s1;
	logic              commit;
	token_t            res [RES_MAX];
	logic [RES_MAX-1:0] res_vld;
	logic [RQ_CNT_W-1:0] space;
	logic [RQ_CNT_W-1:0] need;
	token_t            head;

	always_comb begin
		need = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			need = need + RQ_CNT_W'(res_vld[i]);
		end
	end

	assign commit   = vld_s1 && (need <= space);
	assign in_ready = !vld_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			chr_s1 <= char_byte;
			eos_s1 <= end_of_source;
		end
	end

	elx_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.POS_WIDTH(POS_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(commit),
		.chr(chr_s1),
		.eos(eos_s1),
		.res(res),
		.res_vld(res_vld)
	);

	elx_rq u_rq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(commit),
		.wr_tok(res),
		.wr_vld(res_vld),
		.space(space),
		.rd_valid(out_valid),
		.rd_ready(out_ready),
		.rd_tok(head)
	);

	assign token_kind  = head.kind;
	assign token_char  = head.chr;
	assign start_pos   = head.spos;
	assign token_len   = head.len;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

[rtl/elx_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "expression_lexer_top_macros.svh"

module elx_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [elx_pkg::KIND_W-1:0]  token_kind,
	input wire logic [elx_pkg::CHAR_W-1:0]  token_char,
	input wire logic [elx_pkg::SPOS_W-1:0]  start_pos,
	input wire logic [elx_pkg::LEN_W-1:0]   token_len,
	input wire logic                        last_of_run
);
	import elx_pkg::*;

	`ELX_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(start_pos) && $stable(token_len), "output request changed while stalled")
	`ELX_ASSERT_NOW(a_eof_shape, clk, arst_n, out_valid && token_kind == KIND_EOF, last_of_run && token_len == '0 && token_char == '0, "eof result malformed")
	`ELX_ASSERT_NOW(a_kw_len, clk, arst_n, out_valid && (token_kind == KIND_LET || token_kind == KIND_NULL), token_char == '0 && token_len == ((token_kind == KIND_LET) ? 8'd3 : 8'd4), "keyword length wrong")
	`ELX_ASSERT_NOW(a_single_len, clk, arst_n, out_valid && (token_kind == KIND_LPAREN || token_kind == KIND_RPAREN || token_kind == KIND_ASSIGN || token_kind == KIND_BINOP || token_kind == KIND_ERROR), token_len == 8'd1, "single-character token length wrong")

endmodule

bind expression_lexer_top elx_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.token_kind(token_kind),
	.token_char(token_char),
	.start_pos(start_pos),
	.token_len(token_len),
	.last_of_run(last_of_run)
);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	import elx_pkg::*;

	localparam int MAX_LEN = MAX_TOKEN_LEN_DEF;

	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_ASSIGN = "=";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_DIGITS, SCAN_SKIP} scan_mode_e;
	typedef enum logic [2:0] {
		KW_NONE, KW_L, KW_LE, KW_LET, KW_N, KW_NU, KW_NUL, KW_NULL
	} kw_prefix_e;

	typedef struct {
		logic [7:0] ch;
		logic       eos;
		int         gap;
		bit         drain;
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CHAR_W-1:0] char_byte = '0;
	logic end_of_source = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] token_kind;
	logic [CHAR_W-1:0] token_char;
	logic [SPOS_W-1:0] start_pos;
	logic [LEN_W-1:0] token_len;
	logic last_of_run;

	expression_lexer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.end_of_source(end_of_source),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.token_char(token_char),
		.start_pos(start_pos),
		.token_len(token_len),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// lexer shadow state
	scan_mode_e scan_mode;
	kw_prefix_e kw_state;
	logic [15:0] cur_pos;
	logic [15:0] run_start;
	logic [7:0] run_len;
	token_t step_toks [0:2];
	int step_n;
	token_t expected_tokens [$];

	byte_req_t byte_reqs [$];
	logic [7:0] src_bytes [$];
	byte_req_t next_req;
	bit have_req = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	bit rx_calm = 1'b0;
	int accepted_cnt = 0;
	int total_items = 0;
	int err_cnt = 0;
	string op_chars = "()=+-*/";
	string ws_chars = " \n\t";
	string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic kw_prefix_e next_kw(kw_prefix_e p, logic [7:0] c);
		if (p == KW_L && c == "e") return KW_LE;
		if (p == KW_LE && c == "t") return KW_LET;
		if (p == KW_N && c == "u") return KW_NU;
		if (p == KW_NU && c == "l") return KW_NUL;
		if (p == KW_NUL && c == "l") return KW_NULL;
		return KW_NONE;
	endfunction

	task automatic clear_scan();
		scan_mode = SCAN_IDLE;
		kw_state = KW_NONE;
		cur_pos = '0;
		run_start = '0;
		run_len = '0;
	endtask

	task automatic emit_tok(logic [3:0] kind, logic [7:0] chr, logic [15:0] spos,
			logic [7:0] len);
		step_toks[step_n] = {kind, chr, spos, len, 1'b0};
		step_n++;
	endtask

	task automatic flush_run();
		if (scan_mode == SCAN_WORD) begin
			if (kw_state == KW_LET)
				emit_tok(KIND_LET, 8'd0, run_start, run_len);
			else if (kw_state == KW_NULL)
				emit_tok(KIND_NULL, 8'd0, run_start, run_len);
			else
				emit_tok(KIND_IDENT, 8'd0, run_start, run_len);
			scan_mode = SCAN_IDLE;
		end else if (scan_mode == SCAN_DIGITS) begin
			emit_tok(KIND_NUMBER, 8'd0, run_start, run_len);
			scan_mode = SCAN_IDLE;
		end
	endtask

	task automatic start_run(scan_mode_e m, logic [7:0] c, logic [15:0] here);
		scan_mode = m;
		run_start = here;
		run_len = 8'd1;
		if (m == SCAN_WORD && c == "l")
			kw_state = KW_L;
		else if (m == SCAN_WORD && c == "n")
			kw_state = KW_N;
		else
			kw_state = KW_NONE;
	endtask

	task automatic lex_byte(logic [7:0] c, logic eos);
		logic [15:0] here;
		here = cur_pos;
		step_n = 0;
		if (scan_mode == SCAN_SKIP) begin
			if (eos)
				clear_scan();
			else
				cur_pos = here + 16'd1;
		end else begin
			if ((scan_mode == SCAN_WORD && is_alpha(c)) ||
					(scan_mode == SCAN_DIGITS && is_num(c))) begin
				if (run_len < MAX_LEN)
					run_len = run_len + 8'd1;
				if (scan_mode == SCAN_WORD)
					kw_state = next_kw(kw_state, c);
			end else begin
				flush_run();
				case (c)
					CH_SPACE, CH_NL, CH_TAB: begin
					end
					CH_LPAREN: emit_tok(KIND_LPAREN, c, here, 8'd1);
					CH_RPAREN: emit_tok(KIND_RPAREN, c, here, 8'd1);
					CH_ASSIGN: emit_tok(KIND_ASSIGN, c, here, 8'd1);
					CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: emit_tok(KIND_BINOP, c, here, 8'd1);
					default: begin
						if (is_alpha(c)) begin
							start_run(SCAN_WORD, c, here);
						end else if (is_num(c)) begin
							start_run(SCAN_DIGITS, c, here);
						end else begin
							emit_tok(KIND_ERROR, c, here, 8'd1);
							scan_mode = SCAN_SKIP;
						end
					end
				endcase
			end
			if (eos) begin
				flush_run();
				if (scan_mode != SCAN_SKIP)
					emit_tok(KIND_EOF, 8'd0, here + 16'd1, 8'd0);
				clear_scan();
			end else begin
				cur_pos = here + 16'd1;
			end
			if (step_n > 0)
				step_toks[step_n - 1].last = 1'b1;
			for (int i = 0; i < step_n; i++)
				expected_tokens.push_back(step_toks[i]);
		end
	endtask

	task automatic report_mismatch(string what, token_t got, token_t want);
		err_cnt++;
		$display("%0t %s: kind %0d/%0d char %02h/%02h pos %0d/%0d len %0d/%0d last %0b/%0b (got/exp)",
			$realtime, what, got.kind, want.kind, got.chr, want.chr, got.spos, want.spos,
			got.len, want.len, got.last, want.last);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			src_bytes.push_back(s[i]);
	endtask

	task automatic commit_source(bit calm, bit drain);
		byte_req_t r;
		for (int i = 0; i < src_bytes.size(); i++) begin
			r.ch = src_bytes[i];
			r.eos = (i == src_bytes.size() - 1);
			r.gap = calm ? 0 : $urandom_range(0, 10);
			r.drain = drain && (i == 0);
			byte_reqs.push_back(r);
		end
		src_bytes.delete();
	endtask

	task automatic add_random_token();
		int n;
		if ($urandom_range(0, 39) == 0) begin
			src_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 15))
				0, 1, 2: begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						src_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
				end
				3: add_text("let");
				4: add_text("null");
				5: begin
					case ($urandom_range(0, 7))
						0: add_text("le");
						1: add_text("nu");
						2: add_text("nul");
						3: add_text("lets");
						4: add_text("nulls");
						5: add_text("l");
						6: add_text("n");
						default: add_text("Let");
					endcase
				end
				6, 7, 8: begin
					n = $urandom_range(1, 5);
					for (int i = 0; i < n; i++)
						src_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
				end
				9, 10, 11, 12: src_bytes.push_back(op_chars[$urandom_range(0, 6)]);
				default: src_bytes.push_back(ws_chars[$urandom_range(0, 2)]);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_bytes
		logic free;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_byte <= '0;
			end_of_source <= 1'b0;
			have_req = 1'b0;
			gap_left = 0;
		end else begin
			free = !in_valid;
			if (in_valid && in_ready) begin
				lex_byte(char_byte, end_of_source);
				accepted_cnt++;
				free = 1'b1;
			end
			if (free && !have_req && byte_reqs.size() > 0) begin
				next_req = byte_reqs.pop_front();
				have_req = 1'b1;
				gap_left = next_req.gap;
			end
			if (free && have_req && gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (free && have_req &&
					(!next_req.drain || expected_tokens.size() == 0)) begin
				char_byte <= next_req.ch;
				end_of_source <= next_req.eos;
				in_valid <= 1'b1;
				have_req = 1'b0;
			end else if (free) begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_tokens
		token_t got;
		token_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {token_kind, token_char, start_pos, token_len, last_of_run};
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token", got, '0);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want)
						report_mismatch("token mismatch", got, want);
				end
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int rand_cnt;
		int src_cnt;
		int n;
		clear_scan();

		// all operators, keywords, near-keyword, number, tab and newline
		add_text("let\tnul=(9+null)*Z/a-\n");
		commit_source(1'b0, 1'b0);
		// zero byte, then ignored bytes up to the final one
		add_text("x");
		src_bytes.push_back(8'h00);
		add_text("q");
		commit_source(1'b0, 1'b1);
		src_bytes.push_back(8'hFF);
		commit_source(1'b0, 1'b0);
		add_text("7");
		src_bytes.push_back(8'hFF);
		commit_source(1'b0, 1'b0);
		// three results from the final byte
		add_text("42)");
		commit_source(1'b0, 1'b0);
		// saturating length
		for (int i = 0; i < 300; i++)
			src_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
		add_text(" ");
		commit_source(1'b1, 1'b0);

		rand_cnt = 0;
		src_cnt = 0;
		while (rand_cnt < 110) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				add_random_token();
			rand_cnt += src_bytes.size();
			commit_source($urandom_range(0, 3) == 0, (src_cnt % 6) == 0);
			src_cnt++;
		end
		total_items = byte_reqs.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(accepted_cnt == total_items && expected_tokens.size() == 0))
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/elx_pkg.sv
rtl/elx_core.sv
rtl/elx_rq.sv
rtl/expression_lexer_top.sv
rtl/elx_chk.sv
tb/sv/tb_top.sv
